[src/assert_macros.svh]
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising clock edge outside reset
`define TPJF_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true outside reset
`define TPJF_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

[src/tpjf_pkg.sv]
// Shared types, constants and the coordinate transform for the touch filter
package tpjf_pkg;

	localparam int SLOTS  = 5;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;

	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_X       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_Y       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ORIENTATION = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_BIG_STEP    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_SMALL_STEP  = 3'd6;

	localparam logic [11:0] RST_OFFSET_X    = 12'd40;
	localparam logic [11:0] RST_OFFSET_Y    = 12'd0;
	localparam logic [11:0] RST_MAX_X       = 12'd1820;
	localparam logic [11:0] RST_MAX_Y       = 12'd1280;
	localparam logic [2:0]  RST_ORIENTATION = 3'd6;
	localparam logic [7:0]  RST_BIG_STEP    = 8'd6;
	localparam logic [7:0]  RST_SMALL_STEP  = 8'd2;

	localparam logic FUNC_POINT = 1'b0;
	localparam logic FUNC_FRAME = 1'b1;

	localparam logic [1:0] KIND_TOUCH   = 2'd0;
	localparam logic [1:0] KIND_RELEASE = 2'd1;
	localparam logic [1:0] KIND_SYNC    = 2'd2;

	localparam int POS_W = 16;

	typedef struct packed {
		logic [11:0] offset_x;
		logic [11:0] offset_y;
		logic [11:0] max_x;
		logic [11:0] max_y;
		logic [2:0]  orientation;
		logic [7:0]  big_step;
		logic [7:0]  small_step;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_AVG,
		ST_FILT,
		ST_SCAN,
		ST_SYNC
	} state_t;

	// offset, optional invert per axis, optional swap; 16-bit wrap throughout
	function automatic logic [2*POS_W-1:0] xform(cfg_t c, logic [11:0] rx, logic [11:0] ry);
		logic [POS_W-1:0] x;
		logic [POS_W-1:0] y;
		x = {4'd0, rx} - {4'd0, c.offset_x};
		y = {4'd0, ry} - {4'd0, c.offset_y};
		if (c.orientation[0]) x = {4'd0, c.max_x} - x;
		if (c.orientation[1]) y = {4'd0, c.max_y} - y;
		return c.orientation[2] ? {y, x} : {x, y};
	endfunction

endpackage

[src/tpjf_if.sv]
// Valid/ready channel interfaces for point input and result output
interface tpjf_in_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [2:0]  slot;
	logic [11:0] raw_x;
	logic [11:0] raw_y;

	modport source (output valid, func, slot, raw_x, raw_y, input ready);
	modport sink   (input valid, func, slot, raw_x, raw_y, output ready);
endinterface

interface tpjf_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [2:0]  out_slot;
	logic [15:0] out_x;
	logic [15:0] out_y;
	logic        last;

	modport source (output valid, kind, out_slot, out_x, out_y, last, input ready);
	modport sink   (input valid, kind, out_slot, out_x, out_y, last, output ready);
endinterface

[src/touch_point_jitter_filter.sv]
// Touch point jitter filter top level: config registers, held-position RAM, sequencer.
// Point beat: after acceptance the held position is read from RAM, averaged and filtered
//   (ST_READ, ST_AVG, ST_FILT), written back once the output is free; no new point until ST_IDLE.
// Frame-end beat: one slot scanned per cycle, held while a release waits for output; then sync.
// Output register lets a finished result wait while the input side is served.
// Async active-low reset restores config defaults and clears touch/active flags; RAM is not cleared.
module touch_point_jitter_filter import tpjf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	tpjf_in_if.sink               in_ch,
	tpjf_out_if.source            out_ch
);
	cfg_t               cfg;
	logic               ram_we;
	logic [SLOT_W-1:0]  ram_addr;
	logic [2*POS_W-1:0] ram_wdata, ram_rdata;

	tpjf_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// held x in upper half, held y in lower half
	tpjf_ram #(
		.WIDTH (2*POS_W),
		.DEPTH (SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_addr),
		.wdata (ram_wdata),
		.raddr (ram_addr),
		.rdata (ram_rdata)
	);

	tpjf_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.ram_we    (ram_we),
		.ram_addr  (ram_addr),
		.ram_wdata (ram_wdata),
		.ram_rdata (ram_rdata)
	);
endmodule

[src/tpjf_ram.sv]
// Generic single-write, single-read RAM with registered read data
module tpjf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[src/tpjf_cfg.sv]
// Configuration register file
module tpjf_cfg import tpjf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);
	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.offset_x    <= RST_OFFSET_X;
			cfg_q.offset_y    <= RST_OFFSET_Y;
			cfg_q.max_x       <= RST_MAX_X;
			cfg_q.max_y       <= RST_MAX_Y;
			cfg_q.orientation <= RST_ORIENTATION;
			cfg_q.big_step    <= RST_BIG_STEP;
			cfg_q.small_step  <= RST_SMALL_STEP;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_OFFSET_X:    cfg_q.offset_x    <= cfg_data;
				CFG_OFFSET_Y:    cfg_q.offset_y    <= cfg_data;
				CFG_MAX_X:       cfg_q.max_x       <= cfg_data;
				CFG_MAX_Y:       cfg_q.max_y       <= cfg_data;
				CFG_ORIENTATION: cfg_q.orientation <= cfg_data[2:0];
				CFG_BIG_STEP:    cfg_q.big_step    <= cfg_data[7:0];
				CFG_SMALL_STEP:  cfg_q.small_step  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

[src/tpjf_core.sv]
// Sequencer and datapath: read-modify-write of held positions, frame-end scan
module tpjf_core import tpjf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	tpjf_in_if.sink            in_ch,
	tpjf_out_if.source         out_ch,
	output logic               ram_we,
	output logic [SLOT_W-1:0]  ram_addr,
	output logic [2*POS_W-1:0] ram_wdata,
	input  logic [2*POS_W-1:0] ram_rdata
);
	state_t state_q, state_d;

	logic [2:0]        slot_s1;
	logic [POS_W-1:0]  x_s1, y_s1;
	logic              first_s2;
	logic [POS_W-1:0]  ax_s2, ay_s2, hx_s2, hy_s2;

	logic [SLOTS-1:0]  started_q, act_now_q, act_bef_q;
	logic [SLOT_W-1:0] scan_q;

	logic              out_valid_q, out_last_q;
	logic [1:0]        out_kind_q;
	logic [2:0]        out_slot_q;
	logic [POS_W-1:0]  out_x_q, out_y_q;

	logic              accept, in_range, out_free, rel_hit, scan_done;
	logic [SLOT_W-1:0] sidx;
	logic [2*POS_W-1:0] xy_new;
	logic [POS_W:0]    sum_x, sum_y;
	logic [POS_W-1:0]  ex, ey, nx, ny;
	logic              movx, movy, joint;

	logic              emit, emit_last, in_ready;
	logic [1:0]        emit_kind;
	logic [2:0]        emit_slot;
	logic [POS_W-1:0]  emit_x, emit_y;

	assign accept    = in_ch.valid && in_ready;
	assign in_range  = int'(in_ch.slot) < SLOTS;
	assign out_free  = !out_valid_q || out_ch.ready;
	assign sidx      = slot_s1[SLOT_W-1:0];
	assign rel_hit   = act_bef_q[scan_q] && !act_now_q[scan_q];
	assign scan_done = scan_q == SLOT_W'(SLOTS - 1);
	assign xy_new    = xform(cfg, in_ch.raw_x, in_ch.raw_y);

	assign sum_x = {1'b0, ram_rdata[2*POS_W-1:POS_W]} + {1'b0, x_s1};
	assign sum_y = {1'b0, ram_rdata[POS_W-1:0]} + {1'b0, y_s1};

	// dead-band decision on the averaged step
	always_comb begin
		ex    = (ax_s2 > hx_s2) ? ax_s2 - hx_s2 : hx_s2 - ax_s2;
		ey    = (ay_s2 > hy_s2) ? ay_s2 - hy_s2 : hy_s2 - ay_s2;
		joint = (ex > {8'd0, cfg.big_step} && ey > {8'd0, cfg.small_step}) ||
		        (ex > {8'd0, cfg.small_step} && ey > {8'd0, cfg.big_step});
		movx  = first_s2 || joint || ex > {8'd0, cfg.big_step};
		movy  = first_s2 || joint || ey > {8'd0, cfg.big_step};
		nx    = movx ? ax_s2 : hx_s2;
		ny    = movy ? ay_s2 : hy_s2;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (in_ch.func == FUNC_FRAME) state_d = ST_SCAN;
					else if (in_range)            state_d = ST_READ;
				end
			end
			ST_READ: state_d = ST_AVG;
			ST_AVG:  state_d = ST_FILT;
			ST_FILT: begin
				if (out_free) state_d = ST_IDLE;
			end
			ST_SCAN: begin
				if ((!rel_hit || out_free) && scan_done) state_d = ST_SYNC;
			end
			ST_SYNC: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready  = 1'b0;
		emit      = 1'b0;
		emit_kind = KIND_TOUCH;
		emit_slot = slot_s1;
		emit_x    = nx;
		emit_y    = ny;
		emit_last = 1'b1;
		ram_we    = 1'b0;
		unique case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_FILT: begin
				emit   = out_free;
				ram_we = out_free;
			end
			ST_SCAN: begin
				emit      = rel_hit && out_free;
				emit_kind = KIND_RELEASE;
				emit_slot = 3'(scan_q);
				emit_x    = '0;
				emit_y    = '0;
				emit_last = 1'b0;
			end
			ST_SYNC: begin
				emit      = out_free;
				emit_kind = KIND_SYNC;
				emit_slot = '0;
				emit_x    = '0;
				emit_y    = '0;
			end
			default: ;
		endcase
	end

	assign ram_addr  = sidx;
	assign ram_wdata = {nx, ny};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			started_q   <= '0;
			act_now_q   <= '0;
			act_bef_q   <= '0;
			scan_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			if (accept) begin
				scan_q <= '0;
			end
			if (state_q == ST_FILT && out_free) begin
				started_q[sidx] <= 1'b1;
				act_now_q[sidx] <= 1'b1;
			end
			if (state_q == ST_SCAN && (!rel_hit || out_free)) begin
				if (rel_hit) started_q[scan_q] <= 1'b0;
				if (!scan_done) scan_q <= scan_q + 1'b1;
			end
			if (state_q == ST_SYNC && out_free) begin
				act_bef_q <= act_now_q;
				act_now_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			slot_s1 <= in_ch.slot;
			x_s1    <= xy_new[2*POS_W-1:POS_W];
			y_s1    <= xy_new[POS_W-1:0];
		end
		if (state_q == ST_AVG) begin
			first_s2 <= !started_q[sidx];
			hx_s2    <= ram_rdata[2*POS_W-1:POS_W];
			hy_s2    <= ram_rdata[POS_W-1:0];
			ax_s2    <= started_q[sidx] ? sum_x[POS_W:1] : x_s1;
			ay_s2    <= started_q[sidx] ? sum_y[POS_W:1] : y_s1;
		end
		if (emit) begin
			out_kind_q <= emit_kind;
			out_slot_q <= emit_slot;
			out_x_q    <= emit_x;
			out_y_q    <= emit_y;
			out_last_q <= emit_last;
		end
	end

	assign in_ch.ready     = in_ready;
	assign out_ch.valid    = out_valid_q;
	assign out_ch.kind     = out_kind_q;
	assign out_ch.out_slot = out_slot_q;
	assign out_ch.out_x    = out_x_q;
	assign out_ch.out_y    = out_y_q;
	assign out_ch.last     = out_last_q;
endmodule

[src/tpjf_chk.sv]
// Port-level checker for the touch filter and its bind
`include "assert_macros.svh"

module tpjf_chk import tpjf_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  kind,
	input logic [2:0]  out_slot,
	input logic [15:0] out_x,
	input logic [15:0] out_y,
	input logic        last
);
	`TPJF_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid, "result beat dropped while stalled")
	`TPJF_ASSERT_NEVER(a_kind_code, clk, arst_n, out_valid && kind != KIND_TOUCH && kind != KIND_RELEASE && kind != KIND_SYNC, "undefined result kind")
	`TPJF_ASSERT(a_last_kind, clk, arst_n, out_valid |-> (last == (kind != KIND_RELEASE)), "last flag does not match kind")
	`TPJF_ASSERT(a_rel_zero, clk, arst_n, out_valid && kind == KIND_RELEASE |-> out_x == 16'd0 && out_y == 16'd0, "release carries coordinates")
	`TPJF_ASSERT(a_sync_zero, clk, arst_n, out_valid && kind == KIND_SYNC |-> out_slot == 3'd0 && out_x == 16'd0 && out_y == 16'd0, "frame sync carries payload")
endmodule

bind touch_point_jitter_filter tpjf_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.kind      (out_ch.kind),
	.out_slot  (out_ch.out_slot),
	.out_x     (out_ch.out_x),
	.out_y     (out_ch.out_y),
	.last      (out_ch.last)
);

[tb/sv/touch_point_jitter_filter_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the touch point jitter filter with random stalls on both channels
module touch_point_jitter_filter_tb;
	import tpjf_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
	localparam int SETTLE_CYCLES = 16;

	typedef struct packed {
		logic [1:0]  kind;
		logic [2:0]  slot;
		logic [15:0] x;
		logic [15:0] y;
		logic        last;
	} report_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	tpjf_in_if  in_ch ();
	tpjf_out_if out_ch ();

	touch_point_jitter_filter i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	// shadow of the block's registers and per-slot filter state
	cfg_t             regs_shadow = {RST_OFFSET_X, RST_OFFSET_Y, RST_MAX_X, RST_MAX_Y,
	                                 RST_ORIENTATION, RST_BIG_STEP, RST_SMALL_STEP};
	logic [15:0]      held_x [SLOTS];
	logic [15:0]      held_y [SLOTS];
	logic [SLOTS-1:0] touch_on     = '0;
	logic [SLOTS-1:0] seen_frame   = '0;
	logic [SLOTS-1:0] seen_prev    = '0;
	report_t          pending_reports [$];

	// raw finger trajectories for well-formed random touches
	logic [11:0]      finger_x [SLOTS];
	logic [11:0]      finger_y [SLOTS];

	int fail_count = 0;
	bit no_idle    = 1'b0;
	int hold_len   = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#8_000_000;
		$display("** touch_point_jitter_filter: FAILED **");
		$finish;
	end

	function automatic int pick_gap();
		int roll;
		if (no_idle)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return 0;
		if (roll < 88)
			return $urandom_range(1, 3);
		if (roll < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// result side: random stalls, plus a long hold-off when requested
	initial begin : result_sink
		int stall_left;
		stall_left = 0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_len > 0) begin
				stall_left = hold_len;
				hold_len   = 0;
			end
			if (stall_left > 0) begin
				out_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				out_ch.ready <= 1'b1;
				if (!no_idle && $urandom_range(0, 3) == 0)
					stall_left = pick_gap();
			end
		end
	end

	task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin : result_check
		report_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_reports.size() == 0) begin
				$error("unexpected result beat: kind %0d slot %0d x 0x%0h y 0x%0h last %0d",
				       out_ch.kind, out_ch.out_slot, out_ch.out_x, out_ch.out_y, out_ch.last);
				fail_count++;
			end else begin
				want = pending_reports.pop_front();
				check_field("kind", want.kind, out_ch.kind);
				check_field("out_slot", want.slot, out_ch.out_slot);
				check_field("out_x", want.x, out_ch.out_x);
				check_field("out_y", want.y, out_ch.out_y);
				check_field("last", want.last, out_ch.last);
			end
		end
	end

	task automatic track_point(logic [2:0] slot, logic [11:0] rx, logic [11:0] ry);
		logic [15:0] px, py, tmp, ax, ay, ex, ey;
		logic [16:0] sx, sy;
		logic        mx, my;
		report_t     r;
		if (slot >= SLOTS)
			return;
		px = {4'd0, rx} - {4'd0, regs_shadow.offset_x};
		py = {4'd0, ry} - {4'd0, regs_shadow.offset_y};
		if (regs_shadow.orientation[0])
			px = {4'd0, regs_shadow.max_x} - px;
		if (regs_shadow.orientation[1])
			py = {4'd0, regs_shadow.max_y} - py;
		if (regs_shadow.orientation[2]) begin
			tmp = px;
			px  = py;
			py  = tmp;
		end
		seen_frame[slot] = 1'b1;
		if (!touch_on[slot]) begin
			// first point of a touch passes straight through
			touch_on[slot] = 1'b1;
			held_x[slot]   = px;
			held_y[slot]   = py;
		end else begin
			sx = {1'b0, held_x[slot]} + {1'b0, px};
			sy = {1'b0, held_y[slot]} + {1'b0, py};
			ax = sx[16:1];
			ay = sy[16:1];
			ex = (ax > held_x[slot]) ? ax - held_x[slot] : held_x[slot] - ax;
			ey = (ay > held_y[slot]) ? ay - held_y[slot] : held_y[slot] - ay;
			if ((ex > regs_shadow.big_step && ey > regs_shadow.small_step) ||
			    (ex > regs_shadow.small_step && ey > regs_shadow.big_step)) begin
				mx = 1'b1;
				my = 1'b1;
			end else begin
				mx = ex > regs_shadow.big_step;
				my = ey > regs_shadow.big_step;
			end
			if (mx)
				held_x[slot] = ax;
			if (my)
				held_y[slot] = ay;
		end
		r.kind = KIND_TOUCH;
		r.slot = slot;
		r.x    = held_x[slot];
		r.y    = held_y[slot];
		r.last = 1'b1;
		pending_reports.push_back(r);
	endtask

	task automatic track_frame_end();
		report_t r;
		r.x    = '0;
		r.y    = '0;
		r.last = 1'b0;
		r.kind = KIND_RELEASE;
		for (int i = 0; i < SLOTS; i++) begin
			if (seen_prev[i] && !seen_frame[i]) begin
				touch_on[i] = 1'b0;
				r.slot      = 3'(i);
				pending_reports.push_back(r);
			end
		end
		seen_prev  = seen_frame;
		seen_frame = '0;
		r.kind = KIND_SYNC;
		r.slot = '0;
		r.last = 1'b1;
		pending_reports.push_back(r);
	endtask

	// valid stays high into the next beat when there is no gap
	task automatic send_beat(logic func, logic [2:0] slot, logic [11:0] rx, logic [11:0] ry);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.func  <= func;
		in_ch.slot  <= slot;
		in_ch.raw_x <= rx;
		in_ch.raw_y <= ry;
		do
			@(posedge clk);
		while (!(in_ch.valid && in_ch.ready));
		if (func == FUNC_POINT)
			track_point(slot, rx, ry);
		else
			track_frame_end();
	endtask

	task automatic send_tracked_point(logic [2:0] slot);
		int span, dx, dy;
		span = 2 * int'(regs_shadow.big_step) + 8;
		dx = int'($urandom_range(0, 2 * span)) - span;
		dy = int'($urandom_range(0, 2 * span)) - span;
		finger_x[slot] = finger_x[slot] + 12'(dx);
		finger_y[slot] = finger_y[slot] + 12'(dy);
		send_beat(FUNC_POINT, slot, finger_x[slot], finger_y[slot]);
	endtask

	task automatic drain_results();
		in_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_reports.size() != 0);
		// out-of-range points give nothing back
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			CFG_OFFSET_X:    regs_shadow.offset_x    = data[11:0];
			CFG_OFFSET_Y:    regs_shadow.offset_y    = data[11:0];
			CFG_MAX_X:       regs_shadow.max_x       = data[11:0];
			CFG_MAX_Y:       regs_shadow.max_y       = data[11:0];
			CFG_ORIENTATION: regs_shadow.orientation = data[2:0];
			CFG_BIG_STEP:    regs_shadow.big_step    = data[7:0];
			CFG_SMALL_STEP:  regs_shadow.small_step  = data[7:0];
			default: ;
		endcase
	endtask

	// upper bits of narrow registers carry junk to check masking
	task automatic program_regs(cfg_t c);
		logic [11:0] junk;
		junk = 12'($urandom);
		write_reg(CFG_OFFSET_X, c.offset_x);
		write_reg(CFG_OFFSET_Y, c.offset_y);
		write_reg(CFG_MAX_X, c.max_x);
		write_reg(CFG_MAX_Y, c.max_y);
		write_reg(CFG_ORIENTATION, {junk[11:3], c.orientation});
		write_reg(CFG_BIG_STEP, {junk[11:8], c.big_step});
		write_reg(CFG_SMALL_STEP, {junk[7:4], c.small_step});
		write_reg(CFG_UNUSED, junk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_first_touch_defaults();
		send_beat(FUNC_POINT, 3'd0, 12'd0, 12'd0);        // x offset wraps below zero
		send_beat(FUNC_POINT, 3'd0, 12'hFFF, 12'hFFF);
		send_beat(FUNC_POINT, 3'(SLOTS), 12'hFFF, 12'd0);  // slot out of range
		send_beat(FUNC_FRAME, 3'd7, 12'hFFF, 12'hFFF);
		send_beat(FUNC_FRAME, 3'd0, 12'd0, 12'd0);         // slot 0 released
		send_beat(FUNC_FRAME, 3'd0, 12'd0, 12'd0);         // empty frame
	endtask

	task automatic test_dead_band();
		drain_results();
		program_regs({12'd0, 12'd0, 12'd4095, 12'd4095, 3'd0, 8'd6, 8'd2});
		send_beat(FUNC_POINT, 3'd1, 12'd1000, 12'd1000);
		send_beat(FUNC_POINT, 3'd1, 12'd1016, 12'd1006);   // joint move
		send_beat(FUNC_POINT, 3'd1, 12'd1024, 12'd1008);   // x alone
		send_beat(FUNC_POINT, 3'd1, 12'd1016, 12'd1005);   // inside dead band, same frame
		send_beat(FUNC_POINT, 3'd1, 12'd1016, 12'd1030);   // y alone
		send_beat(FUNC_FRAME, 3'd0, 12'd0, 12'd0);
	endtask

	task automatic test_orientation_extremes();
		drain_results();
		program_regs({12'd4095, 12'd4095, 12'd0, 12'd0, 3'd7, 8'd0, 8'd0});
		send_beat(FUNC_POINT, 3'd4, 12'd0, 12'hFFF);
		send_beat(FUNC_POINT, 3'd4, 12'hFFF, 12'd0);
		send_beat(FUNC_FRAME, 3'd0, 12'd0, 12'd0);
		drain_results();
		program_regs({12'd0, 12'd0, 12'd4095, 12'd4095, 3'd3, 8'd255, 8'd255});
		send_beat(FUNC_POINT, 3'd3, 12'hFFF, 12'hFFF);
		send_beat(FUNC_POINT, 3'd3, 12'd0, 12'd0);
		send_beat(FUNC_FRAME, 3'd0, 12'd0, 12'd0);
		send_beat(FUNC_FRAME, 3'd0, 12'd0, 12'd0);
	endtask

	task automatic test_release_all_slots();
		for (int s = 0; s < SLOTS; s++)
			send_beat(FUNC_POINT, 3'(s), 12'($urandom), 12'($urandom));
		send_beat(FUNC_FRAME, 3'd0, 12'd0, 12'd0);
		send_beat(FUNC_FRAME, 3'd0, 12'd0, 12'd0);         // every slot released at once
	endtask

	task automatic test_output_hold_off();
		hold_len = 300;
		repeat (4) begin
			repeat (5) send_tracked_point(3'($urandom_range(0, SLOTS - 1)));
			send_beat(FUNC_FRAME, 3'($urandom), 12'($urandom), 12'($urandom));
		end
	endtask

	task automatic test_random_frames();
		cfg_t c;
		int   sent, npts, pick;
		for (int phase = 0; phase < 8; phase++) begin
			drain_results();
			case (phase)
				2: c = {12'd4095, 12'd4095, 12'd4095, 12'd4095, 3'd7, 8'd255, 8'd255};
				5: c = {12'd0, 12'd0, 12'd0, 12'd0, 3'd0, 8'd0, 8'd0};
				default: begin
					c.offset_x   = 12'($urandom);
					c.offset_y   = 12'($urandom);
					c.max_x      = 12'($urandom);
					c.max_y      = 12'($urandom);
					c.big_step   = 8'($urandom_range(0, 40));
					c.small_step = 8'($urandom_range(0, 40));
				end
			endcase
			c.orientation = 3'(phase);
			no_idle = (phase == 6);
			program_regs(c);
			sent = 0;
			while (sent < 34) begin
				npts = $urandom_range(0, 6);
				repeat (npts) begin
					pick = $urandom_range(0, 19);
					if (pick == 0) begin
						// ignored beat, not counted
						send_beat(FUNC_POINT, 3'($urandom_range(SLOTS, 7)),
						          12'($urandom), 12'($urandom));
					end else begin
						if (pick == 1)
							send_beat(FUNC_POINT, 3'($urandom_range(0, SLOTS - 1)),
							          12'($urandom), 12'($urandom));
						else
							send_tracked_point(3'($urandom_range(0, SLOTS - 1)));
						sent++;
					end
				end
				send_beat(FUNC_FRAME, 3'($urandom), 12'($urandom), 12'($urandom));
				sent++;
			end
		end
		no_idle = 1'b0;
	endtask

	initial begin
		arst_n      <= 1'b0;
		cfg_we      <= 1'b0;
		cfg_index   <= '0;
		cfg_data    <= '0;
		in_ch.valid <= 1'b0;
		in_ch.func  <= FUNC_POINT;
		in_ch.slot  <= '0;
		in_ch.raw_x <= '0;
		in_ch.raw_y <= '0;
		for (int s = 0; s < SLOTS; s++) begin
			finger_x[s] = 12'($urandom);
			finger_y[s] = 12'($urandom);
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_first_touch_defaults();
		test_dead_band();
		test_orientation_extremes();
		test_release_all_slots();
		test_output_hold_off();
		test_random_frames();

		drain_results();
		if (fail_count == 0)
			$display("** touch_point_jitter_filter: PASSED **");
		else
			$display("** touch_point_jitter_filter: FAILED **");
		$finish;
	end

endmodule

[filelist.f]
+incdir+src
src/tpjf_pkg.sv
src/tpjf_if.sv
src/tpjf_ram.sv
src/tpjf_cfg.sv
src/tpjf_core.sv
src/touch_point_jitter_filter.sv
src/tpjf_chk.sv
tb/sv/touch_point_jitter_filter_tb.sv
